/* rtl/sil_pkg.sv */
// ----------------------------------------------------------------------------
// sil_pkg
// Types and constants shared by the sectioned interpolation lookup modules.
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int TIME_W  = 40;  // unsigned 24.16 time
    localparam int SEC_W   = 7;
    localparam int BAR_W   = 17;
    localparam int FRAC_W  = 16;
    localparam int HALF_W  = 16;
    localparam int SPAN_W  = BAR_W + FRAC_W;      // a bar number with 16 fraction bits
    localparam int POS_W   = SPAN_W + 1;          // whole bars plus an unreduced fraction
    localparam int STEPS   = TIME_W;              // bits consumed by the serial unit
    localparam int STEP_CW = $clog2(STEPS);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SECTION = 2'd1,
        STAT_FULL       = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WALK,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef enum logic {
        MODE_DIV,
        MODE_SCALE
    } t_unit_mode;

    typedef struct packed {
        logic       start;
        t_unit_mode mode;
    } t_unit_req;

endpackage

/* rtl/sectioned_interpolation_lookup_top.sv */
// ----------------------------------------------------------------------------
// sectioned_interpolation_lookup_top
// Anchor table with per-section piecewise linear time lookup.
// ----------------------------------------------------------------------------
// Input words arrive on i_valid/o_ready, each carrying a command: clear the
// anchor table, append one anchor (time, section, bar), or query a position
// whole + num/den within a section. Every word yields exactly one result word
// (status, seek_time) on o_valid/i_ready, in order.
// One word is worked on at a time; o_ready is high only while idle.
// A query runs the fraction division on the shared serial unit, walks the
// stored anchors through the table RAM read port in table order and, when
// the position falls between two anchors of the section, runs the
// interpolation ratio on the same unit before the result is handed over.
// The result sits in an output register; a new word is taken while it waits,
// and the next result is held back until the receiver has taken the first.
// Reset empties the table (the count goes to zero) and drops any result.
// ----------------------------------------------------------------------------
module sectioned_interpolation_lookup_top
    import sil_pkg::*;
#(
    parameter int ANCHOR_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [TIME_W-1:0] i_anchor_time,
    input  logic [SEC_W-1:0]  i_section_id,
    input  logic [BAR_W-1:0]  i_anchor_bar,
    input  logic [BAR_W-1:0]  i_query_whole,
    input  logic [HALF_W-1:0] i_query_num,
    input  logic [HALF_W-1:0] i_query_den,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [TIME_W-1:0] o_seek_time
);

    localparam int AW      = $clog2(ANCHOR_DEPTH);
    localparam int CW      = $clog2(ANCHOR_DEPTH + 1);
    localparam int ENTRY_W = TIME_W + SEC_W + BAR_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic [SEC_W-1:0]  r_sect;
    logic [BAR_W-1:0]  r_whole;
    logic              r_den_zero;
    logic [POS_W-1:0]  r_pos;
    logic              r_have_prev;
    logic [TIME_W-1:0] r_pt;
    logic [SPAN_W-1:0] r_pb;
    logic              r_desc;
    t_status           r_res_status;
    logic [TIME_W-1:0] r_res_time;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [TIME_W-1:0] r_out_time;

    logic              w_in_acc;
    logic              w_full;
    logic              w_we;
    logic [ENTRY_W-1:0] w_rdata;
    logic [TIME_W-1:0] w_e_time;
    logic [SEC_W-1:0]  w_e_sect;
    logic [SPAN_W-1:0] w_bar16;
    logic              w_match;
    logic              w_first_hit;
    logic              w_mid_hit;
    logic              w_issue;
    logic              w_walk_end;
    logic              w_e_desc;
    logic              w_out_load;
    t_unit_req         w_req;
    logic [SPAN_W-1:0] w_ua;
    logic [TIME_W-1:0] w_ub;
    logic [SPAN_W-1:0] w_uc;
    logic              w_udone;
    logic [TIME_W-1:0] w_uquo;

    assign w_in_acc = i_valid && o_ready;
    assign w_full   = r_count == CW'(ANCHOR_DEPTH);
    assign w_we     = w_in_acc && i_cmd == CMD_APPEND && !w_full;

    sil_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ANCHOR_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_anchor_time, i_section_id, i_anchor_bar}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Walk: the table read data is registered, so it arrives in the cycle after its address.
    assign w_e_time    = w_rdata[ENTRY_W-1 -: TIME_W];
    assign w_e_sect    = w_rdata[BAR_W +: SEC_W];
    assign w_bar16     = {w_rdata[BAR_W-1:0], FRAC_W'(0)};
    assign w_match     = r_state == ST_WALK && r_pend && w_e_sect == r_sect;
    assign w_first_hit = w_match && !r_have_prev && r_pos <= POS_W'(w_bar16);
    assign w_mid_hit   = w_match && r_have_prev && r_pos < POS_W'(w_bar16);
    assign w_issue     = r_idx < r_count;
    assign w_walk_end  = !r_pend && !w_issue;
    assign w_e_desc    = w_e_time < r_pt;

    sil_serial_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_ua),
        .i_b     (w_ub),
        .i_c     (w_uc),
        .o_done  (w_udone),
        .o_quo   (w_uquo)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_cmd == CMD_QUERY) ? ST_DIVIDE : ST_OUT;
                end
            end
            ST_DIVIDE: begin
                if (w_udone) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_mid_hit) begin
                    n_state = ST_SCALE;
                end else if (w_first_hit || (!w_match && w_walk_end)) begin
                    n_state = ST_OUT;
                end
            end
            ST_SCALE: begin
                if (w_udone) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs and unit operands.
    always_comb begin
        o_ready    = r_state == ST_IDLE;
        w_out_load = r_state == ST_OUT && (!r_out_valid || i_ready);
        w_req      = '{start: 1'b0, mode: MODE_DIV};
        w_ua       = '0;
        w_ub       = TIME_W'({i_query_num, FRAC_W'(0)});
        w_uc       = SPAN_W'(i_query_den);
        case (r_state)
            ST_IDLE: begin
                w_req.start = w_in_acc && i_cmd == CMD_QUERY;
            end
            ST_WALK: begin
                w_req = '{start: w_mid_hit, mode: MODE_SCALE};
                w_ua  = r_pos[SPAN_W-1:0] - r_pb;
                w_ub  = w_e_desc ? (r_pt - w_e_time) : (w_e_time - r_pt);
                w_uc  = w_bar16 - r_pb;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_cmd == CMD_CLEAR) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_WALK) begin
                r_pend <= w_issue;
            end else begin
                r_pend <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_res_status <= (i_cmd == CMD_APPEND && w_full) ? STAT_FULL : STAT_OK;
                r_res_time   <= '0;
                r_sect       <= i_section_id;
                r_whole      <= i_query_whole;
                r_den_zero   <= i_query_den == '0;
            end
            ST_DIVIDE: begin
                r_pos       <= POS_W'({r_whole, FRAC_W'(0)})
                             + (r_den_zero ? '0 : POS_W'(w_uquo[2*HALF_W-1:0]));
                r_idx       <= '0;
                r_have_prev <= 1'b0;
            end
            ST_WALK: begin
                r_idx <= r_idx + CW'(w_issue);
                if (w_first_hit) begin
                    r_res_status <= STAT_OK;
                    r_res_time   <= w_e_time;
                end else if (w_mid_hit) begin
                    r_desc <= w_e_desc;
                end else if (w_match) begin
                    r_have_prev <= 1'b1;
                    r_pt        <= w_e_time;
                    r_pb        <= w_bar16;
                end else if (w_walk_end) begin
                    r_res_status <= r_have_prev ? STAT_OK : STAT_NO_SECTION;
                    r_res_time   <= r_have_prev ? r_pt : '0;
                end
            end
            ST_SCALE: begin
                if (w_udone) begin
                    r_res_status <= STAT_OK;
                    r_res_time   <= r_desc ? (r_pt - w_uquo) : (r_pt + w_uquo);
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_time   <= r_res_time;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_seek_time = r_out_time;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ANCHOR_DEPTH))
        else $error("anchor count beyond table depth");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd == CMD_APPEND && w_full) |=> $stable(r_count))
        else $error("append to a full table changed the count");

    a_unit_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_udone |-> (r_state == ST_DIVIDE || r_state == ST_SCALE))
        else $error("serial unit finished outside a waiting state");

    a_time_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seek_time != '0) |-> o_status == STAT_OK)
        else $error("non-zero seek time with an error status");

endmodule

/* rtl/sil_ram.sv */
// ----------------------------------------------------------------------------
// sil_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sil_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sil_serial_unit.sv */
// ----------------------------------------------------------------------------
// sil_serial_unit
// Shared compare-and-subtract unit. It runs either a restoring division of b
// by c, or floor(a * b / c) for a < c, one bit of b per step, MSB first.
// ----------------------------------------------------------------------------
module sil_serial_unit
    import sil_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_req         i_req,
    input  logic [SPAN_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    input  logic [SPAN_W-1:0] i_c,
    output logic              o_done,
    output logic [TIME_W-1:0] o_quo
);

    logic               r_busy;
    logic               r_done;
    logic               r_phase;
    t_unit_mode         r_mode;
    logic [STEP_CW-1:0] r_cnt;
    logic [SPAN_W-1:0]  r_a;
    logic [TIME_W-1:0]  r_b;
    logic [SPAN_W-1:0]  r_c;
    logic [SPAN_W-1:0]  r_rem;
    logic [TIME_W-1:0]  r_quo;

    logic [SPAN_W:0]    w_t;
    logic               w_ge;
    logic [SPAN_W:0]    w_red;
    logic               w_bit;
    logic               w_advance;

    assign w_bit = r_b[TIME_W-1];

    // Phase 0 doubles the remainder (bringing in the next dividend bit when
    // dividing); phase 1 adds a when the current bit of b is set.
    always_comb begin
        if (r_phase) begin
            w_t = {1'b0, r_rem} + {1'b0, r_a};
        end else if (r_mode == MODE_DIV) begin
            w_t = {r_rem, w_bit};
        end else begin
            w_t = {r_rem, 1'b0};
        end
        w_ge  = w_t >= {1'b0, r_c};
        w_red = w_ge ? (w_t - {1'b0, r_c}) : w_t;
    end

    assign w_advance = r_phase || (r_mode == MODE_DIV) || !w_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_advance && r_cnt == STEP_CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode  <= i_req.mode;
            r_a     <= i_a;
            r_b     <= i_b;
            r_c     <= i_c;
            r_rem   <= '0;
            r_quo   <= '0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_rem <= w_red[SPAN_W-1:0];
            if (r_phase) begin
                r_quo <= r_quo + TIME_W'(w_ge);
            end else begin
                r_quo <= {r_quo[TIME_W-2:0], w_ge};
            end
            if (w_advance) begin
                r_phase <= 1'b0;
                r_b     <= {r_b[TIME_W-2:0], 1'b0};
                r_cnt   <= r_cnt + 1'b1;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* bench/sil_tb_pkg.sv */
// ----------------------------------------------------------------------------
// sil_tb_pkg
// Word types and the result scoreboard for the sectioned interpolation lookup
// testbench. The scoreboard keeps its own anchor table, predicts the result of
// every accepted word and checks the results in order as they come out.
// ----------------------------------------------------------------------------
package sil_tb_pkg;

    import sil_pkg::*;

    localparam int         ANCHOR_DEPTH = 256;
    localparam int         BAR_MAX      = (1 << BAR_W) - 1;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    typedef struct {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] anchor_time;
        logic [SEC_W-1:0]  section_id;
        logic [BAR_W-1:0]  anchor_bar;
        logic [BAR_W-1:0]  query_whole;
        logic [HALF_W-1:0] query_num;
        logic [HALF_W-1:0] query_den;
    } t_lookup_word;

    typedef struct {
        t_status           status;
        logic [TIME_W-1:0] seek_time;
    } t_seek_result;

    class seek_scoreboard;

        logic [TIME_W-1:0] stored_times    [ANCHOR_DEPTH];
        logic [SEC_W-1:0]  stored_sections [ANCHOR_DEPTH];
        logic [BAR_W-1:0]  stored_bars     [ANCHOR_DEPTH];
        int unsigned       stored_count;
        t_seek_result      pending_results [$];

        int unsigned clears;
        int unsigned appends;
        int unsigned full_appends;
        int unsigned unused_words;
        int unsigned queries;
        int unsigned interpolated;
        int unsigned clamped;
        int unsigned missing_sections;
        int unsigned results_checked;
        int unsigned mismatch_count;

        function new();
            stored_count = 0;
        endfunction

        // floor(offset * rise / span); the product can need more than 64 bits.
        function logic [TIME_W-1:0] scaled_span(longint unsigned offset,
                                                logic [TIME_W-1:0] rise,
                                                longint unsigned span);
            logic [79:0] product;
            logic [79:0] quotient;
            product  = 80'(offset) * 80'(rise);
            quotient = product / 80'(span);
            return quotient[TIME_W-1:0];
        endfunction

        // Walks the anchors of one section in table order. Returns 0 when the
        // section holds no anchor at all.
        function bit locate_seek(logic [SEC_W-1:0] section, longint unsigned position,
                                 output logic [TIME_W-1:0] seek);
            bit                seen;
            logic [TIME_W-1:0] prev_time;
            longint unsigned   prev_bar;
            longint unsigned   bar16;
            seen      = 1'b0;
            prev_time = '0;
            prev_bar  = 0;
            seek      = '0;
            for (int i = 0; i < stored_count; i++) begin
                if (stored_sections[i] != section) continue;
                bar16 = 64'(stored_bars[i]) << FRAC_W;
                if (!seen && position <= bar16) begin
                    clamped++;
                    seek = stored_times[i];
                    return 1'b1;
                end
                if (seen && position < bar16) begin
                    interpolated++;
                    if (stored_times[i] >= prev_time) begin
                        seek = prev_time + scaled_span(position - prev_bar,
                                                       stored_times[i] - prev_time,
                                                       bar16 - prev_bar);
                    end else begin
                        seek = prev_time - scaled_span(position - prev_bar,
                                                       prev_time - stored_times[i],
                                                       bar16 - prev_bar);
                    end
                    return 1'b1;
                end
                seen      = 1'b1;
                prev_time = stored_times[i];
                prev_bar  = bar16;
            end
            if (seen) clamped++;
            seek = prev_time;
            return seen;
        endfunction

        function t_seek_result predict_seek(t_lookup_word w);
            t_seek_result      r;
            longint unsigned   position;
            logic [TIME_W-1:0] seek;
            r.status    = STAT_OK;
            r.seek_time = '0;
            case (w.cmd)
                CMD_CLEAR: begin
                    clears++;
                    stored_count = 0;
                end
                CMD_APPEND: begin
                    appends++;
                    if (stored_count >= ANCHOR_DEPTH) begin
                        full_appends++;
                        r.status = STAT_FULL;
                    end else begin
                        stored_times[stored_count]    = w.anchor_time;
                        stored_sections[stored_count] = w.section_id;
                        stored_bars[stored_count]     = w.anchor_bar;
                        stored_count++;
                    end
                end
                CMD_QUERY: begin
                    queries++;
                    position = 64'(w.query_whole) << FRAC_W;
                    // A zero denominator leaves the fraction out altogether.
                    if (w.query_den != '0)
                        position += (64'(w.query_num) << FRAC_W) / 64'(w.query_den);
                    if (locate_seek(w.section_id, position, seek)) begin
                        r.seek_time = seek;
                    end else begin
                        missing_sections++;
                        r.status = STAT_NO_SECTION;
                    end
                end
                default: begin
                    unused_words++;
                end
            endcase
            return r;
        endfunction

        function void note_word(t_lookup_word w);
            t_seek_result due;
            due = predict_seek(w);
            pending_results.insert(pending_results.size(), due);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(logic [1:0] status, logic [TIME_W-1:0] seek_time);
            t_seek_result exp;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word (status %0d, seek 0x%h) with none due",
                                          status, seek_time));
                return;
            end
            exp = pending_results.pop_front();
            results_checked++;
            if (status !== exp.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
            if (seek_time !== exp.seek_time)
                report_mismatch($sformatf("seek_time 0x%h, expected 0x%h",
                                          seek_time, exp.seek_time));
        endtask

        function int unsigned pending_count();
            return pending_results.size();
        endfunction

    endclass

endpackage

/* bench/tb_sectioned_interpolation_lookup_top.sv */
// ----------------------------------------------------------------------------
// tb_sectioned_interpolation_lookup_top
// Self-checking testbench for the sectioned interpolation lookup.
// ----------------------------------------------------------------------------
// A directed opening covers empty and cleared tables, clamping at both ends of
// a section, rising and falling interpolation, zero and oversized fractions
// and the unused command. Random episodes then build tables over a few
// sections with rising bars, query around them, fill the table past its
// depth, and mix in unformed words. Both sides idle at random in the first two
// phases; in the third the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_sectioned_interpolation_lookup_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sil_pkg::*;
    import sil_tb_pkg::*;

    localparam int HALF_PERIOD_NS = 1;
    localparam int RESET_CYCLES   = 10;
    localparam int PHASE_WORDS    = 550;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_cmd;
    logic [TIME_W-1:0] i_anchor_time;
    logic [SEC_W-1:0]  i_section_id;
    logic [BAR_W-1:0]  i_anchor_bar;
    logic [BAR_W-1:0]  i_query_whole;
    logic [HALF_W-1:0] i_query_num;
    logic [HALF_W-1:0] i_query_den;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_status;
    logic [TIME_W-1:0] o_seek_time;

    seek_scoreboard scoreboard;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    int unsigned    words_sent;
    bit             hold_request;

    sectioned_interpolation_lookup_top #(
        .ANCHOR_DEPTH(ANCHOR_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_anchor_time (i_anchor_time),
        .i_section_id  (i_section_id),
        .i_anchor_bar  (i_anchor_bar),
        .i_query_whole (i_query_whole),
        .i_query_num   (i_query_num),
        .i_query_den   (i_query_den),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_seek_time   (o_seek_time)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    function automatic t_lookup_word random_word();
        t_lookup_word w;
        w.cmd         = 2'($urandom_range(0, 3));
        w.anchor_time = {8'($urandom), $urandom};
        w.section_id  = 7'($urandom);
        w.anchor_bar  = 17'($urandom);
        w.query_whole = 17'($urandom);
        w.query_num   = 16'($urandom);
        w.query_den   = 16'($urandom);
        return w;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic offer_word(input t_lookup_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= w.cmd;
        i_anchor_time <= w.anchor_time;
        i_section_id  <= w.section_id;
        i_anchor_bar  <= w.anchor_bar;
        i_query_whole <= w.query_whole;
        i_query_num   <= w.query_num;
        i_query_den   <= w.query_den;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scoreboard.note_word(w);
        if (w.cmd != CMD_UNUSED) words_sent++;
    endtask

    task automatic send_clear();
        t_lookup_word w;
        w     = random_word();
        w.cmd = CMD_CLEAR;
        offer_word(w);
    endtask

    task automatic send_unused();
        t_lookup_word w;
        w     = random_word();
        w.cmd = CMD_UNUSED;
        offer_word(w);
    endtask

    task automatic send_append(input logic [TIME_W-1:0] anchor_time,
                               input logic [SEC_W-1:0] section, input int bar);
        t_lookup_word w;
        w             = random_word();
        w.cmd         = CMD_APPEND;
        w.anchor_time = anchor_time;
        w.section_id  = section;
        w.anchor_bar  = BAR_W'(bar);
        offer_word(w);
    endtask

    task automatic send_query(input logic [SEC_W-1:0] section, input int whole,
                              input int num, input int den);
        t_lookup_word w;
        w             = random_word();
        w.cmd         = CMD_QUERY;
        w.section_id  = section;
        w.query_whole = BAR_W'(whole);
        w.query_num   = HALF_W'(num);
        w.query_den   = HALF_W'(den);
        offer_word(w);
    endtask

    // Clears the table, appends rising anchors spread over a few sections and
    // queries positions around them. With fill_table set the table is run past
    // its depth so that the last appends are refused.
    task automatic run_table_episode(input bit fill_table);
        logic [SEC_W-1:0]  sections   [4];
        int                first_bar  [4];
        int                last_bar   [4];
        int                held       [4];
        logic [TIME_W-1:0] last_time  [4];
        logic [TIME_W-1:0] time_step;
        logic [TIME_W-1:0] anchor_time;
        logic [SEC_W-1:0]  section;
        int                n_sec, n_anchors, n_queries, j, whole, num, den, pick;
        bit                wild_times;
        n_sec      = $urandom_range(1, 4);
        n_anchors  = fill_table ? ANCHOR_DEPTH + $urandom_range(1, 3) : $urandom_range(1, 12);
        n_queries  = fill_table ? $urandom_range(3, 6) : $urandom_range(3, 10);
        wild_times = ($urandom_range(0, 99) < 15);
        for (int k = 0; k < 4; k++) begin
            sections[k]  = ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                        : 7'($urandom_range(1, 99));
            last_bar[k]  = (!fill_table && $urandom_range(0, 9) == 0)
                           ? BAR_MAX - 300 : $urandom_range(0, 1000);
            first_bar[k] = last_bar[k];
            held[k]      = 0;
            last_time[k] = {8'($urandom), $urandom} >> $urandom_range(0, 24);
        end
        send_clear();
        for (int k = 0; k < n_anchors; k++) begin
            j = $urandom_range(0, n_sec - 1);
            last_bar[j] += fill_table ? $urandom_range(1, 2) : $urandom_range(1, 20);
            if (held[j] == 0) first_bar[j] = last_bar[j];
            held[j]++;
            time_step = 40'($urandom) >> $urandom_range(0, 31);
            time_step = (time_step << $urandom_range(0, 8)) + 1'b1;
            last_time[j] += time_step;
            anchor_time   = wild_times ? {8'($urandom), $urandom} : last_time[j];
            send_append(anchor_time, sections[j], last_bar[j]);
        end
        for (int q = 0; q < n_queries; q++) begin
            j = $urandom_range(0, n_sec - 1);
            if (held[j] == 0 || $urandom_range(0, 9) == 0) begin
                section = 7'($urandom);
                whole   = $urandom_range(0, BAR_MAX);
            end else begin
                section = sections[j];
                whole   = first_bar[j] - 2 + $urandom_range(0, last_bar[j] - first_bar[j] + 4);
                if (whole < 0) whole = 0;
                if (whole > BAR_MAX) whole = BAR_MAX;
            end
            pick = $urandom_range(0, 9);
            den  = $urandom_range(1, 65535);
            if (pick == 0) begin
                den = 0;
                num = $urandom_range(0, 65535);
            end else if (pick == 1) begin
                num = $urandom_range(den, 65535);
            end else if (pick == 2) begin
                num = 0;
            end else begin
                num = $urandom_range(0, den - 1);
            end
            send_query(section, whole, num, den);
        end
    endtask

    task automatic run_noise_episode();
        repeat ($urandom_range(3, 10)) offer_word(random_word());
    endtask

    // Receiver: checks every result word taken and idles or holds off on request.
    initial begin
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) scoreboard.check_result(o_status, o_seek_time);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("FAIL sectioned_interpolation_lookup_top");
        $finish;
    end

    initial begin
        bit first_episode;
        int unsigned phase_end;
        scoreboard    = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        words_sent    = 0;
        hold_request  = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = CMD_CLEAR;
        i_anchor_time = '0;
        i_section_id  = '0;
        i_anchor_bar  = '0;
        i_query_whole = '0;
        i_query_num   = '0;
        i_query_den   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty table, then a small table over four sections.
        send_query(7'd5, 0, 0, 1);
        send_unused();
        send_append(40'h00_0000_0000, 7'd1, 1);
        send_append(40'hFF_FFFF_FFFF, 7'd2, 10);
        send_append(40'h00_0010_0000, 7'd1, 5);
        send_append(40'h00_0000_0001, 7'd2, 20);
        send_append(40'h12_3456_789A, 7'd127, BAR_MAX);
        send_append(40'hFF_FFFF_FFFF, 7'd1, BAR_MAX);
        send_append(40'h55_5555_5555, 7'd0, 0);
        send_query(7'd1, 0, 0, 1);
        send_query(7'd1, 1, 0, 1);
        send_query(7'd1, 3, 1, 3);
        send_query(7'd2, 15, 65534, 65535);
        send_query(7'd2, 25, 0, 1);
        send_query(7'd1, BAR_MAX, 65535, 1);
        send_query(7'd1, 7, 5, 0);
        send_query(7'd127, BAR_MAX, 65534, 65535);
        send_query(7'd0, 0, 0, 65535);
        send_query(7'd98, 3, 0, 1);
        // Widest span with the largest offset and time rise.
        send_query(7'd1, BAR_MAX - 1, 65534, 65535);
        send_clear();
        send_query(7'd1, 3, 0, 1);
        send_unused();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 0) begin
                send_idle_pct = 8;
                recv_idle_pct = 50;
            end else if (phase == 1) begin
                send_idle_pct = 50;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;
            end
            phase_end     = words_sent + PHASE_WORDS;
            first_episode = 1'b1;
            while (words_sent < phase_end) begin
                if (first_episode && phase != 1) run_table_episode(1'b1);
                else if ($urandom_range(0, 99) < 3) run_table_episode(1'b1);
                else if ($urandom_range(0, 99) < 80) run_table_episode(1'b0);
                else run_noise_episode();
                first_episode = 1'b0;
            end
        end
        i_valid <= 1'b0;

        while (scoreboard.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d clears, %0d appends (%0d refused on a full table), %0d unused words.",
                 scoreboard.clears, scoreboard.appends, scoreboard.full_appends,
                 scoreboard.unused_words);
        $display("%0d queries: %0d interpolated, %0d clamped, %0d without section; %0d checked.",
                 scoreboard.queries, scoreboard.interpolated, scoreboard.clamped,
                 scoreboard.missing_sections, scoreboard.results_checked);
        if (scoreboard.mismatch_count == 0 && scoreboard.pending_count() == 0) begin
            $display("PASS sectioned_interpolation_lookup_top");
        end else begin
            $display("FAIL sectioned_interpolation_lookup_top");
        end
        $finish;
    end

endmodule
